### rtl/sspq_pkg.sv
// ----------------------------------------------------------------------------
// sspq_pkg: shared types and constants of the sorted priority queue
// Capacity, field widths, operation and status codes, cell control bundle.
// ----------------------------------------------------------------------------
package sspq_pkg;

	localparam int CAPACITY = 16;
	localparam int VALUE_W  = 32;
	localparam int PRIO_W   = 8;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int ECNT_W   = 5;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_REMOVE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_REMOVED  = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	// Broadcast to every cell in the cycle an item is taken.
	typedef struct packed {
		logic               ins_en;
		logic               rem_en;
		logic [VALUE_W-1:0] value;
		logic [PRIO_W-1:0]  prio;
	} cell_ctl_t;

	typedef struct packed {
		status_t            status;
		logic [VALUE_W-1:0] value;
		logic [PRIO_W-1:0]  prio;
		logic [ECNT_W-1:0]  count;
	} result_t;

endpackage

### rtl/sspq_cell.sv
// ----------------------------------------------------------------------------
// sspq_cell: one slot of the sorted queue
// Holds one entry; on insert it keeps, takes the new entry or takes its left
// neighbour, on removal it takes its right neighbour.
// ----------------------------------------------------------------------------
module sspq_cell (
	input  logic                        clk,
	input  sspq_pkg::cell_ctl_t         ctl,
	input  logic                        occ,
	input  logic                        left_greater,
	input  logic [sspq_pkg::VALUE_W-1:0] left_value,
	input  logic [sspq_pkg::PRIO_W-1:0]  left_prio,
	input  logic [sspq_pkg::VALUE_W-1:0] right_value,
	input  logic [sspq_pkg::PRIO_W-1:0]  right_prio,
	output logic                        greater,
	output logic [sspq_pkg::VALUE_W-1:0] slot_value,
	output logic [sspq_pkg::PRIO_W-1:0]  slot_prio
);
	import sspq_pkg::*;

	logic [VALUE_W-1:0] value_q;
	logic [PRIO_W-1:0]  prio_q;

	// An empty slot counts as greater, so the new entry lands at the tail
	// when no held entry outranks it. Equal priorities stay in front.
	assign greater    = !occ || (prio_q > ctl.prio);
	assign slot_value = value_q;
	assign slot_prio  = prio_q;

	always_ff @(posedge clk) begin
		if (ctl.ins_en) begin
			if (greater && !left_greater) begin
				value_q <= ctl.value;
				prio_q  <= ctl.prio;
			end else if (greater) begin
				value_q <= left_value;
				prio_q  <= left_prio;
			end
		end else if (ctl.rem_en) begin
			value_q <= right_value;
			prio_q  <= right_prio;
		end
	end

endmodule

### rtl/sspq_obuf.sv
// ----------------------------------------------------------------------------
// sspq_obuf: output register with skid stage
// Holds up to two results so the queue keeps taking items while one waits.
// ----------------------------------------------------------------------------
module sspq_obuf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  sspq_pkg::result_t   push_data,
	output logic                space,
	output logic                out_valid,
	input  logic                out_ready,
	output sspq_pkg::result_t   out_data
);
	import sspq_pkg::*;

	logic    main_valid_q;
	logic    skid_valid_q;
	result_t main_q;
	result_t skid_q;
	logic    pop;

	assign pop       = main_valid_q && out_ready;
	assign space     = !skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_data  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (!main_valid_q) begin
				main_valid_q <= push;
			end else if (pop) begin
				main_valid_q <= skid_valid_q || push;
				skid_valid_q <= 1'b0;
			end else if (push) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!main_valid_q || (pop && !skid_valid_q)) begin
			main_q <= push_data;
		end else if (pop) begin
			main_q <= skid_q;
		end
		if (main_valid_q && !pop && push) begin
			skid_q <= push_data;
		end
	end

endmodule

### rtl/stable_sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue: bounded, stable sorted priority queue
// A row of slot cells kept in ascending priority order; inserts shift the
// tail right, removals shift the whole row left and return the front.
// ----------------------------------------------------------------------------
//  Channel  Direction  tdata                                 tuser
//  s_axis   in         item_value, item_priority             op
//  m_axis   out        out_value, out_priority, entry_count  status
//
//  Every item is handled in the cycle of its transfer: all cells compare
//  against the new priority and shift at once, so one item a cycle is taken
//  while s_axis_tready is high. The result goes to an output register backed
//  by a skid stage; s_axis_tready drops only while both hold a result that
//  has not been taken. Reset clears the entry count and the output buffer;
//  slot contents are left as they are and read only once written.
// ----------------------------------------------------------------------------
module stable_sorted_priority_queue (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // item_value[31:0], item_priority[39:32]
	input  logic [0:0]  s_axis_tuser,  // op[0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // out_value[31:0], out_priority[39:32],
	                                   // entry_count[44:40], zero above
	output logic [1:0]  m_axis_tuser   // status[1:0]
);
	import sspq_pkg::*;

	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   count_next;
	logic               take;
	logic               is_ins;
	logic               full;
	logic               empty;
	cell_ctl_t          ctl;
	result_t            res;
	result_t            out_res;
	logic               space;
	logic [CNT_W+ECNT_W-1:0] count_ext;

	logic [VALUE_W-1:0] slot_value [CAPACITY];
	logic [PRIO_W-1:0]  slot_prio  [CAPACITY];
	logic [CAPACITY-1:0] greater;
	logic [CAPACITY-1:0] occ;

	assign take   = s_axis_tvalid && s_axis_tready;
	assign is_ins = (op_t'(s_axis_tuser[0]) == OP_INSERT);
	assign full   = (count_q == CNT_W'(CAPACITY));
	assign empty  = (count_q == '0);

	assign ctl.ins_en = take && is_ins && !full;
	assign ctl.rem_en = take && !is_ins && !empty;
	assign ctl.value  = s_axis_tdata[VALUE_W-1:0];
	assign ctl.prio   = s_axis_tdata[VALUE_W+PRIO_W-1:VALUE_W];

	always_comb begin
		count_next = count_q;
		if (ctl.ins_en) begin
			count_next = count_q + 1'b1;
		end else if (ctl.rem_en) begin
			count_next = count_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_next;
		end
	end

	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			assign occ[gi] = (CNT_W'(gi) < count_q);
			if (gi == 0) begin : g_head
				sspq_cell u_cell (
					.clk          (clk),
					.ctl          (ctl),
					.occ          (occ[gi]),
					.left_greater (1'b0),
					.left_value   (ctl.value),
					.left_prio    (ctl.prio),
					.right_value  (slot_value[gi+1]),
					.right_prio   (slot_prio[gi+1]),
					.greater      (greater[gi]),
					.slot_value   (slot_value[gi]),
					.slot_prio    (slot_prio[gi])
				);
			end else if (gi == CAPACITY - 1) begin : g_tail
				sspq_cell u_cell (
					.clk          (clk),
					.ctl          (ctl),
					.occ          (occ[gi]),
					.left_greater (greater[gi-1]),
					.left_value   (slot_value[gi-1]),
					.left_prio    (slot_prio[gi-1]),
					.right_value  (slot_value[gi]),
					.right_prio   (slot_prio[gi]),
					.greater      (greater[gi]),
					.slot_value   (slot_value[gi]),
					.slot_prio    (slot_prio[gi])
				);
			end else begin : g_mid
				sspq_cell u_cell (
					.clk          (clk),
					.ctl          (ctl),
					.occ          (occ[gi]),
					.left_greater (greater[gi-1]),
					.left_value   (slot_value[gi-1]),
					.left_prio    (slot_prio[gi-1]),
					.right_value  (slot_value[gi+1]),
					.right_prio   (slot_prio[gi+1]),
					.greater      (greater[gi]),
					.slot_value   (slot_value[gi]),
					.slot_prio    (slot_prio[gi])
				);
			end
		end
	endgenerate

	assign count_ext = {{ECNT_W{1'b0}}, count_next};

	always_comb begin
		res.value = '0;
		res.prio  = '0;
		res.count = count_ext[ECNT_W-1:0];
		if (is_ins) begin
			res.status = full ? ST_FULL : ST_INSERTED;
		end else if (empty) begin
			res.status = ST_EMPTY;
		end else begin
			res.status = ST_REMOVED;
			res.value  = slot_value[0];
			res.prio   = slot_prio[0];
		end
	end

	sspq_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (take),
		.push_data (res),
		.space     (space),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (out_res)
	);

	assign s_axis_tready = space;
	assign m_axis_tuser  = out_res.status;
	assign m_axis_tdata  = {3'b000, out_res.count, out_res.prio, out_res.value};

	// The count never runs past the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	// An accepted insert into a queue with room grows it by exactly one.
	a_ins_grows: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.ins_en |=> (count_q == $past(count_q) + 1'b1))
		else $error("insert did not grow the queue");

	// The two front slots stay in priority order while both are held.
	a_front_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		occ[1] |-> (slot_prio[0] <= slot_prio[1]))
		else $error("front slots out of order");

endmodule

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for stable_sorted_priority_queue
// Inserts and removals are streamed in with random gaps and the results are
// taken with random back-pressure. Every result is compared field by field
// against a behavioural queue that is kept sorted and stable on equal
// priorities, including the refused insert on a full queue and the removal
// from an empty one.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import sspq_pkg::*;

	localparam int CYCLE_LIMIT = 100000;
	localparam int RANDOM_ITEMS = 580;
	localparam int QUIET_TAIL = 150;
	localparam int SHOWN_ERRORS = 10;

	typedef struct {
		op_t                op;
		logic [VALUE_W-1:0] value;
		logic [PRIO_W-1:0]  prio;
	} request_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;   // item_value[31:0], item_priority[39:32]
	logic [0:0]  s_axis_tuser = '0;   // op[0]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;        // out_value[31:0], out_priority[39:32],
	                                  // entry_count[44:40]
	logic [1:0]  m_axis_tuser;        // status[1:0]

	request_t pending_requests[$];
	result_t  expected_results[$];

	// Behavioural copy of the queue contents, front first.
	logic [VALUE_W-1:0] model_value[CAPACITY];
	logic [PRIO_W-1:0]  model_prio[CAPACITY];
	int model_count = 0;

	int total_requests = 0;
	int sent_count = 0;
	int cycle_count = 0;
	int error_count = 0;
	int checked_count = 0;
	int insert_count = 0;
	int full_count = 0;
	int remove_count = 0;
	int empty_count = 0;
	int gap_left = 0;
	int stall_left = 0;
	logic item_taken = 1'b0;
	logic quiet_tail;

	assign quiet_tail = (sent_count + QUIET_TAIL >= total_requests);

	stable_sorted_priority_queue dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #5 clk = ~clk;

	function automatic result_t apply_request(request_t rq);
		result_t r;
		int pos;
		int i;
		r = '0;
		if (rq.op == OP_INSERT) begin
			if (model_count >= CAPACITY) begin
				r.status = ST_FULL;
				full_count++;
			end else begin
				// A new entry goes behind every entry of equal or smaller priority.
				pos = 0;
				while (pos < model_count && model_prio[pos] <= rq.prio)
					pos++;
				for (i = model_count; i > pos; i--) begin
					model_value[i] = model_value[i-1];
					model_prio[i] = model_prio[i-1];
				end
				model_value[pos] = rq.value;
				model_prio[pos] = rq.prio;
				model_count++;
				r.status = ST_INSERTED;
				insert_count++;
			end
		end else begin
			if (model_count == 0) begin
				r.status = ST_EMPTY;
				empty_count++;
			end else begin
				r.value = model_value[0];
				r.prio = model_prio[0];
				for (i = 1; i < model_count; i++) begin
					model_value[i-1] = model_value[i];
					model_prio[i-1] = model_prio[i];
				end
				model_count--;
				r.status = ST_REMOVED;
				remove_count++;
			end
		end
		r.count = model_count[ECNT_W-1:0];
		return r;
	endfunction

	task automatic note_mismatch(string field, logic [31:0] want, logic [31:0] got);
		error_count++;
		if (error_count <= SHOWN_ERRORS)
			$display("mismatch on result %0d, %s: expected 0x%0h, got 0x%0h",
				checked_count, field, want, got);
	endtask

	task automatic add_request(op_t op, logic [VALUE_W-1:0] value, logic [PRIO_W-1:0] prio);
		request_t rq;
		rq.op = op;
		rq.value = value;
		rq.prio = prio;
		pending_requests.push_back(rq);
	endtask

	// Input transfers feed the prediction; output transfers are checked.
	always @(posedge clk) begin
		result_t want;
		request_t rq;
		item_taken <= s_axis_tvalid && s_axis_tready;
		if (s_axis_tvalid && s_axis_tready) begin
			rq.op = op_t'(s_axis_tuser[0]);
			rq.value = s_axis_tdata[31:0];
			rq.prio = s_axis_tdata[39:32];
			expected_results.push_back(apply_request(rq));
		end
		if (m_axis_tvalid && m_axis_tready) begin
			if (expected_results.size() == 0) begin
				error_count++;
				if (error_count <= SHOWN_ERRORS)
					$display("unexpected result: status %0d value 0x%0h prio %0d count %0d",
						m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[39:32],
						m_axis_tdata[44:40]);
			end else begin
				want = expected_results.pop_front();
				if (m_axis_tuser !== want.status)
					note_mismatch("status", 32'(want.status), 32'(m_axis_tuser));
				if (m_axis_tdata[31:0] !== want.value)
					note_mismatch("out_value", want.value, m_axis_tdata[31:0]);
				if (m_axis_tdata[39:32] !== want.prio)
					note_mismatch("out_priority", 32'(want.prio),
						32'(m_axis_tdata[39:32]));
				if (m_axis_tdata[44:40] !== want.count)
					note_mismatch("entry_count", 32'(want.count),
						32'(m_axis_tdata[44:40]));
				checked_count++;
			end
		end
	end

	// Request driver: holds an item until its transfer, with random gaps between items.
	always @(negedge clk) begin
		request_t rq;
		if (arst_n && (!s_axis_tvalid || item_taken)) begin
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				s_axis_tvalid <= 1'b0;
			end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
				gap_left <= $urandom_range(0, 8);
				s_axis_tvalid <= 1'b0;
			end else if (pending_requests.size() != 0) begin
				rq = pending_requests.pop_front();
				s_axis_tdata <= {rq.prio, rq.value};
				s_axis_tuser <= rq.op;
				s_axis_tvalid <= 1'b1;
				sent_count <= sent_count + 1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Result back-pressure in bursts.
	always @(negedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_axis_tready <= 1'b0;
		end else if (!quiet_tail && $urandom_range(0, 6) == 0) begin
			stall_left <= $urandom_range(0, 8);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		int n;
		int bias;
		op_t op;
		logic [PRIO_W-1:0] prio;

		// Directed part: empty removal, a fill to capacity with extreme values and
		// repeated priorities, a refused insert, then a few removals.
		add_request(OP_REMOVE, 32'hFFFF_FFFF, 8'hFF);
		add_request(OP_INSERT, 32'h7FFF_FFFF, 8'd255);
		add_request(OP_INSERT, 32'h8000_0000, 8'd0);
		add_request(OP_INSERT, 32'h0000_0000, 8'd128);
		add_request(OP_INSERT, 32'hFFFF_FFFF, 8'd0);
		add_request(OP_INSERT, 32'h0000_0001, 8'd128);
		add_request(OP_INSERT, 32'h0000_0002, 8'd128);
		add_request(OP_INSERT, 32'h0000_0003, 8'd255);
		add_request(OP_INSERT, 32'h55AA_55AA, 8'd7);
		add_request(OP_INSERT, 32'hAA55_AA55, 8'd7);
		add_request(OP_INSERT, 32'h1234_5678, 8'd1);
		add_request(OP_INSERT, 32'h8765_4321, 8'd254);
		add_request(OP_INSERT, 32'hDEAD_BEEF, 8'd0);
		add_request(OP_INSERT, 32'hCAFE_F00D, 8'd64);
		add_request(OP_INSERT, 32'h0F0F_0F0F, 8'd64);
		add_request(OP_INSERT, 32'hF0F0_F0F0, 8'd200);
		add_request(OP_INSERT, 32'h1111_1111, 8'd200);
		add_request(OP_INSERT, 32'h0000_0099, 8'd3);
		for (n = 0; n < 4; n++)
			add_request(OP_REMOVE, $urandom, 8'($urandom));

		// Random part: phases lean towards inserts or removals so that the
		// queue swings between full and empty; narrow priorities give many ties.
		bias = 50;
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 40 == 0)
				bias = ((n / 40) % 2 == 0) ? $urandom_range(65, 85) : $urandom_range(15, 35);
			op = ($urandom_range(0, 99) < bias) ? OP_INSERT : OP_REMOVE;
			if ($urandom_range(0, 3) == 0)
				prio = 8'($urandom_range(0, 255));
			else
				prio = 8'($urandom_range(0, 5));
			add_request(op, $urandom, prio);
		end
		total_requests = pending_requests.size();

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		while (pending_requests.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (expected_results.size() != 0) begin
			error_count++;
			$display("%0d results never arrived", expected_results.size());
		end

		$display("%0d requests: %0d inserts taken, %0d refused as full, %0d removals,",
			total_requests, insert_count, full_count, remove_count);
		$display("%0d removals on an empty queue; %0d results checked, %0d errors",
			empty_count, checked_count, error_count);
		if (error_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
